// ===== src/lowest_free_number_allocator_assert.svh =====
// assertion macros used by the allocator top level
`ifndef LOWEST_FREE_NUMBER_ALLOCATOR_ASSERT_SVH
`define LOWEST_FREE_NUMBER_ALLOCATOR_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define LFNA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator check failed");

// next-cycle implication, disabled while reset is high
`define LFNA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator check failed");

`endif

// ===== src/lfna_pkg.sv =====
// types and constants of the lowest free number allocator
package lfna_pkg;

   localparam int MAX_VALUE  = 1024;
   localparam int NUMBER_W   = 11;
   localparam int SLOT_W     = $clog2(MAX_VALUE);
   localparam int CELL_BITS  = 32;
   localparam int BIT_IDX_W  = $clog2(CELL_BITS);
   localparam int CELL_COUNT = MAX_VALUE / CELL_BITS;
   localparam int CELL_IDX_W = SLOT_W - BIT_IDX_W;

   localparam logic CMD_TAKE = 1'b0;

   typedef struct packed {
      logic                cmd;
      logic [NUMBER_W-1:0] value;
   } lfna_req_type;

   typedef struct packed {
      logic [NUMBER_W-1:0] number;
      logic                exhausted;
   } lfna_rsp_type;

   // write strobes broadcast to every cell
   typedef struct packed {
      logic                  set;
      logic                  clr;
      logic [CELL_IDX_W-1:0] cell_sel;
      logic [BIT_IDX_W-1:0]  bit_sel;
   } lfna_cell_ctl_type;

   // search link handed from cell to cell
   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] slot;
   } lfna_link_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } lfna_state_type;

endpackage

// ===== src/lfna_cell.sv =====
// one bitmap cell: a word of returned flags and its registered lowest-set summary
module lfna_cell
   import lfna_pkg::*;
#(
   parameter int CELL_ID = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  lfna_cell_ctl_type ctl,
   input  lfna_link_type     link_in,
   output lfna_link_type     link_out
);

   logic [CELL_BITS-1:0] map_ff, map_in;
   logic                 any_ff, any_in;
   logic [BIT_IDX_W-1:0] low_ff, low_in;
   logic                 hit_here;

   // word update for returns and takes aimed at this cell
   always_comb begin
      map_in = map_ff;
      if (ctl.cell_sel == CELL_IDX_W'(CELL_ID)) begin
         if (ctl.set) begin
            map_in[ctl.bit_sel] = 1'b1;
         end
         if (ctl.clr) begin
            map_in[ctl.bit_sel] = 1'b0;
         end
      end
   end

   // lowest set flag within the stored word
   always_comb begin
      any_in = |map_ff;
      low_in = '0;
      for (int i = CELL_BITS - 1; i >= 0; i--) begin
         if (map_ff[i]) begin
            low_in = BIT_IDX_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff <= '0;
         any_ff <= 1'b0;
         low_ff <= '0;
      end else begin
         map_ff <= map_in;
         any_ff <= any_in;
         low_ff <= low_in;
      end
   end

   // claim the link only when no lower cell holds a returned number
   assign hit_here       = any_ff & ~link_in.found;
   assign link_out.found = link_in.found | any_ff;
   assign link_out.slot  = hit_here ? {CELL_IDX_W'(CELL_ID), low_ff} : link_in.slot;

endmodule

// ===== src/lowest_free_number_allocator.sv =====
// top level of the lowest free number allocator
//
// Hands out the lowest free number in 1..1024. A request with cmd take
// returns one response carrying the number, or number 0 with exhausted set
// when every number is in use. A request with cmd return frees a number that
// was handed out; it gives no response, and returns of zero, of numbers not
// yet handed out or already free are ignored.
// Both channels use valid/stall: a request is taken when req_valid is high
// and req_stall low, a response when rsp_valid is high and rsp_stall low.
// Each request is captured in the idle state and then executed in the
// execute state, which searches the chain of 32 bitmap cells and updates
// the map or watermark; no new request is taken until it is back in idle.
// The search needs the cell summaries, registered in the cycle after each
// map write. A take response is written to the output register as the
// execute state ends. While an earlier response is stalled, a take waits in
// the execute state; a return still completes.
// Synchronous reset empties the bitmap, sets the watermark to 1 and drops
// rsp_valid; no clearing pass is needed afterwards.
module lowest_free_number_allocator
   import lfna_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  lfna_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output lfna_rsp_type rsp_data
);

   lfna_state_type      state_ff, state_in;
   lfna_req_type        req_ff, req_in;
   logic [NUMBER_W-1:0] watermark_ff, watermark_in;
   logic                rsp_valid_ff, rsp_valid_in;
   lfna_rsp_type        rsp_data_ff, rsp_data_in;

   lfna_cell_ctl_type   ctl;
   lfna_link_type       link [CELL_COUNT+1];

   logic                is_take;
   logic                out_free;
   logic                ret_ok;
   logic [SLOT_W-1:0]   ret_slot;
   logic                map_hit;
   logic [SLOT_W-1:0]   map_slot;

   // chain of bitmap cells, searched from the lowest cell upwards
   assign link[0] = '0;
   for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
      lfna_cell #(
         .CELL_ID (k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .link_in  (link[k]),
         .link_out (link[k+1])
      );
   end

   assign map_hit  = link[CELL_COUNT].found;
   assign map_slot = link[CELL_COUNT].slot;

   // request decode
   assign is_take  = (req_ff.cmd == CMD_TAKE);
   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign ret_ok   = (req_ff.value != '0) && (req_ff.value < watermark_ff) &&
                     (req_ff.value <= NUMBER_W'(MAX_VALUE));
   assign ret_slot = SLOT_W'(req_ff.value - NUMBER_W'(1));

   // next state, map strobes and response
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      watermark_in  = watermark_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_data_in   = rsp_data_ff;
      req_stall     = 1'b1;
      ctl.set       = 1'b0;
      ctl.clr       = 1'b0;
      ctl.cell_sel  = map_slot[SLOT_W-1:BIT_IDX_W];
      ctl.bit_sel   = map_slot[BIT_IDX_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               req_in   = req_data;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!is_take) begin
               ctl.set      = ret_ok;
               ctl.cell_sel = ret_slot[SLOT_W-1:BIT_IDX_W];
               ctl.bit_sel  = ret_slot[BIT_IDX_W-1:0];
               state_in     = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               if (map_hit) begin
                  ctl.clr               = 1'b1;
                  rsp_data_in.number    = NUMBER_W'(map_slot) + NUMBER_W'(1);
                  rsp_data_in.exhausted = 1'b0;
               end else if (watermark_ff <= NUMBER_W'(MAX_VALUE)) begin
                  rsp_data_in.number    = watermark_ff;
                  rsp_data_in.exhausted = 1'b0;
                  watermark_in          = watermark_ff + NUMBER_W'(1);
               end else begin
                  rsp_data_in.number    = '0;
                  rsp_data_in.exhausted = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         watermark_ff <= NUMBER_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         watermark_ff <= watermark_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `include "lowest_free_number_allocator_assert.svh"

   `LFNA_ASSERT_IMPL(a_exhausted_zero, clock, reset, rsp_valid_ff && rsp_data_ff.exhausted, rsp_data_ff.number == '0)
   `LFNA_ASSERT_IMPL(a_given_below_wm, clock, reset, rsp_valid_ff && !rsp_data_ff.exhausted, (rsp_data_ff.number != '0) && (rsp_data_ff.number < watermark_ff))
   `LFNA_ASSERT_IMPL(a_wm_range, clock, reset, 1'b1, (watermark_ff >= NUMBER_W'(1)) && (watermark_ff <= NUMBER_W'(MAX_VALUE + 1)))
   `LFNA_ASSERT_NEXT(a_wm_step, clock, reset, (state_ff == ST_EXEC) && is_take && out_free && !map_hit && (watermark_ff <= NUMBER_W'(MAX_VALUE)), watermark_ff == $past(watermark_ff) + NUMBER_W'(1))

endmodule
